[hdl/sfhe_pkg.sv]
package sfhe_pkg;

  // Type byte fields
  localparam logic [7:0] TYPE_BASE = 8'hC1;
  localparam logic [7:0] FIN_BIT   = 8'h20;

  // Longest header: type + 4 id + 8 offset + 2 length
  localparam int MAX_BYTES = 15;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // Offset size codes
  typedef enum logic [1:0] {
    OFF_NONE = 2'd0,
    OFF_2B   = 2'd1,
    OFF_4B   = 2'd2,
    OFF_8B   = 2'd3
  } off_code_t;

  typedef logic [7:0] byte_t;

  // Bytes the offset takes for a given code
  function automatic logic [3:0] off_bytes(input off_code_t code);
    logic [3:0] n;
    begin
      case (code)
        OFF_NONE: n = 4'd0;
        OFF_2B:   n = 4'd2;
        OFF_4B:   n = 4'd4;
        OFF_8B:   n = 4'd8;
        default:  n = 4'd0;
      endcase
      return n;
    end
  endfunction

endpackage

[hdl/stream_frame_header_encoder_core.sv]
// Stream frame header encoder. A chunk descriptor is taken on a clock edge
// with start high and busy low; the block then emits the frame header one
// byte per cycle on header_byte, each byte marked by a one-cycle strobe,
// the final one also by last_byte. The receiver cannot stall: it must take
// every strobed word. A frame header is 4 to 15 words (type, 1-4 id bytes,
// 0/2/4/8 offset bytes, 2 length bytes); a chunk that does not fit gives a
// single word with fits low. An accepted descriptor passes a three-stage
// pipeline and then the output serializer before its first word appears. The
// serializer takes a new item only once the previous one's last word is out;
// if the next item waits in stage 3, its first word follows that word directly.
// busy rises while the pipeline is full behind a serializer still emitting.
module stream_frame_header_encoder_core
  import sfhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] stream_id,
  input  logic [63:0] byte_offset,
  input  logic [15:0] chunk_length,
  input  logic        fin_flag,
  input  logic [15:0] room_left,
  output logic        strobe,
  output logic [7:0]  header_byte,
  output logic        last_byte,
  output logic        fits,
  output logic [15:0] taken_length,
  output logic        was_split,
  output logic [63:0] rest_offset,
  output logic [15:0] rest_length
);

  // ---------------- flow control ----------------
  logic             s1_valid, s2_valid, s3_valid;
  logic [CNT_W-1:0] rem;        // words still queued in serializer
  logic             ser_ready;
  logic             s3_free, s2_free, s1_free, accept;

  assign ser_ready = (rem == '0);
  assign s3_free   = !s3_valid || ser_ready;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign busy      = !s1_free;
  assign accept    = start && !busy;

  // ---------------- stage 1: capture, classify id and offset ----------------
  logic [2:0]  id_len_next;
  off_code_t   off_code_next;

  always_comb begin
    if (stream_id[31:24] != 8'd0)      id_len_next = 3'd4;
    else if (stream_id[23:16] != 8'd0) id_len_next = 3'd3;
    else if (stream_id[15:8] != 8'd0)  id_len_next = 3'd2;
    else                               id_len_next = 3'd1;

    if (byte_offset == 64'd0)               off_code_next = OFF_NONE;
    else if (byte_offset[63:16] == 48'd0)   off_code_next = OFF_2B;
    else if (byte_offset[63:32] == 32'd0)   off_code_next = OFF_4B;
    else                                    off_code_next = OFF_8B;
  end

  logic [31:0] s1_sid;
  logic [63:0] s1_off;
  logic [15:0] s1_len, s1_room;
  logic        s1_fin;
  logic [2:0]  s1_id_len;
  off_code_t   s1_off_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
    if (s1_free) begin
      s1_sid      <= stream_id;
      s1_off      <= byte_offset;
      s1_len      <= chunk_length;
      s1_fin      <= fin_flag;
      s1_room     <= room_left;
      s1_id_len   <= id_len_next;
      s1_off_code <= off_code_next;
    end
  end

  // ---------------- stage 2: fit check and split ----------------
  logic [3:0]  hdr_next;    // header length in bytes
  logic        fit_next;
  logic [15:0] avail_next;
  logic        split_next;

  always_comb begin
    hdr_next   = 4'd3 + {1'b0, s1_id_len} + off_bytes(s1_off_code);
    fit_next   = (s1_room > {12'd0, hdr_next});
    avail_next = s1_room - {12'd0, hdr_next};
    split_next = fit_next && (avail_next < s1_len);
  end

  logic [31:0] s2_sid;
  logic [63:0] s2_off;
  logic [15:0] s2_taken, s2_rlen;
  logic        s2_fin, s2_fit, s2_split;
  logic [2:0]  s2_id_len;
  off_code_t   s2_off_code;
  logic [3:0]  s2_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s2_free) begin
      s2_sid      <= s1_sid;
      s2_off      <= s1_off;
      s2_fit      <= fit_next;
      s2_split    <= split_next;
      s2_fin      <= s1_fin && !split_next;
      s2_taken    <= !fit_next ? 16'd0 : (split_next ? avail_next : s1_len);
      s2_rlen     <= split_next ? (s1_len - avail_next) : 16'd0;
      s2_id_len   <= s1_id_len;
      s2_off_code <= s1_off_code;
      s2_hdr      <= hdr_next;
    end
  end

  // ---------------- stage 3: lay out bytes, remainder offset ----------------
  byte_t            bytes_next [MAX_BYTES];
  logic [CNT_W-1:0] count_next;
  logic [63:0]      roff_next;

  always_comb begin
    logic [3:0] pos;
    logic [3:0] id_end;
    logic [3:0] off_end;
    logic [3:0] rel;
    id_end  = {1'b0, s2_id_len};
    off_end = id_end + off_bytes(s2_off_code);
    for (int p = 0; p < MAX_BYTES; p++) begin
      pos = 4'(p);
      rel = 4'd0;
      if (!s2_fit) begin
        bytes_next[p] = 8'd0;
      end else if (pos == 4'd0) begin
        bytes_next[p] = TYPE_BASE | {3'd0, s2_id_len[1:0] - 2'd1, 3'd0}
                      | {5'd0, s2_off_code, 1'b0}
                      | (s2_fin ? FIN_BIT : 8'd0);
      end else if (pos <= id_end) begin
        rel = id_end - pos;
        bytes_next[p] = s2_sid[{rel[1:0], 3'b000} +: 8];
      end else if (pos <= off_end) begin
        rel = off_end - pos;
        bytes_next[p] = s2_off[{rel[2:0], 3'b000} +: 8];
      end else if (pos == off_end + 4'd1) begin
        bytes_next[p] = s2_taken[15:8];
      end else begin
        bytes_next[p] = s2_taken[7:0];
      end
    end
    count_next = s2_fit ? CNT_W'(s2_hdr) : CNT_W'(1);
    roff_next  = s2_split ? (s2_off + {48'd0, s2_taken}) : 64'd0;
  end

  byte_t            s3_bytes [MAX_BYTES];
  logic [CNT_W-1:0] s3_count;
  logic [63:0]      s3_roff;
  logic [15:0]      s3_taken, s3_rlen;
  logic             s3_fit, s3_split;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
    if (s3_free) begin
      s3_bytes <= bytes_next;
      s3_count <= count_next;
      s3_roff  <= roff_next;
      s3_taken <= s2_taken;
      s3_rlen  <= s2_rlen;
      s3_fit   <= s2_fit;
      s3_split <= s2_split;
    end
  end

  // ---------------- serializer: one word per cycle ----------------
  // sh holds the words after the one on the output; shifts down each cycle while emitting.
  byte_t sh [MAX_BYTES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      rem    <= '0;
    end else if (ser_ready) begin
      strobe <= s3_valid;
      if (s3_valid) begin
        rem <= s3_count - CNT_W'(1);
      end
    end else begin
      strobe <= 1'b1;
      rem    <= rem - CNT_W'(1);
    end

    if (ser_ready) begin
      if (s3_valid) begin
        header_byte  <= s3_bytes[0];
        last_byte    <= (s3_count == CNT_W'(1));
        fits         <= s3_fit;
        taken_length <= s3_taken;
        was_split    <= s3_split;
        rest_offset  <= s3_roff;
        rest_length  <= s3_rlen;
        for (int i = 0; i < MAX_BYTES - 1; i++) begin
          sh[i] <= s3_bytes[i+1];
        end
      end
    end else begin
      header_byte <= sh[0];
      last_byte   <= (rem == CNT_W'(1));
      for (int i = 0; i < MAX_BYTES - 2; i++) begin
        sh[i] <= sh[i+1];
      end
    end
  end

endmodule

[bench/stream_frame_header_encoder_core_tb.sv]
`timescale 1ns / 100ps

module stream_frame_header_encoder_core_tb
  import sfhe_pkg::*;
;

  // One chunk descriptor as driven on the input ports
  typedef struct {
    logic [31:0] sid;
    logic [63:0] offset;
    logic [15:0] len;
    logic        fin;
    logic [15:0] room;
  } chunk_t;

  // One header word as seen on the result ports
  typedef struct {
    byte_t       hbyte;
    logic        last;
    logic        fits;
    logic [15:0] taken;
    logic        split;
    logic [63:0] roff;
    logic [15:0] rlen;
  } hdr_word_t;

  // How a directed row gets its expectation: fully predicted, a hand-typed
  // no-fit word, or a hand-typed type byte with the rest predicted.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_FIT,
    ROW_TYPE
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    chunk_t    chunk;
    byte_t     type_byte;
  } dir_row_t;

  localparam int N_DIR = 23;

  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // Directed rows: minimum frames, full extremes, every id width and offset
  // size with their boundaries, exact fit vs split, offset wrap, zero length.
  dir_row_t dir_rows [N_DIR] = '{
    // smallest frame, room exactly enough
    '{ROW_TYPE,    '{32'h0, 64'h0, 16'h0, 1'b0, 16'd5}, 8'hC1},
    // one byte short of the smallest frame
    '{ROW_NO_FIT,  '{32'h0, 64'h0, 16'h0, 1'b0, 16'd4}, 8'h00},
    // everything at max, no room at all
    '{ROW_NO_FIT,  '{32'hFFFF_FFFF, ONES64, 16'hFFFF, 1'b1, 16'h0}, 8'h00},
    // everything at max: split, fin dropped
    '{ROW_TYPE,    '{32'hFFFF_FFFF, ONES64, 16'hFFFF, 1'b1, 16'hFFFF}, 8'hDF},
    // longest header, one byte short
    '{ROW_NO_FIT,  '{32'hFFFF_FFFF, ONES64, 16'd1, 1'b1, 16'd15}, 8'h00},
    // longest header, one data byte fits exactly
    '{ROW_TYPE,    '{32'hFFFF_FFFF, ONES64, 16'd1, 1'b1, 16'd16}, 8'hFF},
    // longest header, split down to one byte
    '{ROW_PREDICT, '{32'hFFFF_FFFF, ONES64, 16'd2, 1'b1, 16'd16}, 8'h00},
    '{ROW_TYPE,    '{32'h12, 64'h0, 16'd10, 1'b1, 16'd100}, 8'hE1},
    '{ROW_TYPE,    '{32'h1234, 64'h10, 16'h20, 1'b0, 16'h40}, 8'hCB},
    '{ROW_TYPE,    '{32'h12_3456, 64'h1_2345, 16'h200, 1'b0, 16'h1000}, 8'hD5},
    '{ROW_TYPE,    '{32'h1234_5678, 64'h100_0000_0000, 16'h300, 1'b1, 16'h400}, 8'hFF},
    // offset size boundaries against id width boundaries
    '{ROW_PREDICT, '{32'h0, 64'h1, 16'd5, 1'b0, 16'd20}, 8'h00},
    '{ROW_PREDICT, '{32'hFF, 64'hFFFF, 16'd5, 1'b1, 16'd20}, 8'h00},
    '{ROW_PREDICT, '{32'h100, 64'h1_0000, 16'd5, 1'b0, 16'd20}, 8'h00},
    '{ROW_PREDICT, '{32'hFFFF, 64'hFFFF_FFFF, 16'd9, 1'b1, 16'd20}, 8'h00},
    '{ROW_PREDICT, '{32'h1_0000, 64'h1_0000_0000, 16'd9, 1'b0, 16'd30}, 8'h00},
    '{ROW_PREDICT, '{32'hFF_FFFF, 64'h8000_0000_0000_0000, 16'h8000, 1'b1, 16'h8000},
      8'h00},
    // data fills the room exactly: no split, fin kept
    '{ROW_TYPE,    '{32'h1, 64'h2, 16'd100, 1'b1, 16'd106}, 8'hE3},
    // one byte less: split, fin cleared
    '{ROW_TYPE,    '{32'h1, 64'h2, 16'd100, 1'b1, 16'd105}, 8'hC3},
    // remainder offset wraps past 2^64
    '{ROW_PREDICT, '{32'h1, 64'hFFFF_FFFF_FFFF_FFF0, 16'h100, 1'b0, 16'h50}, 8'h00},
    // zero-length chunk carrying only fin
    '{ROW_TYPE,    '{32'hABCD, 64'h0, 16'h0, 1'b1, 16'd7}, 8'hE9},
    // alternating bit patterns
    '{ROW_PREDICT, '{32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b0, 16'h5555},
      8'h00},
    '{ROW_PREDICT, '{32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b1, 16'hAAAA},
      8'h00}
  };

  localparam int N_RANDOM = 187;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] stream_id;
  logic [63:0] byte_offset;
  logic [15:0] chunk_length;
  logic        fin_flag;
  logic [15:0] room_left;
  logic        strobe;
  logic [7:0]  header_byte;
  logic        last_byte;
  logic        fits;
  logic [15:0] taken_length;
  logic        was_split;
  logic [63:0] rest_offset;
  logic [15:0] rest_length;

  // Header words still owed by the block, oldest first
  hdr_word_t pending_words[$];
  int        n_fail = 0;

  stream_frame_header_encoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .stream_id    (stream_id),
    .byte_offset  (byte_offset),
    .chunk_length (chunk_length),
    .fin_flag     (fin_flag),
    .room_left    (room_left),
    .strobe       (strobe),
    .header_byte  (header_byte),
    .last_byte    (last_byte),
    .fits         (fits),
    .taken_length (taken_length),
    .was_split    (was_split),
    .rest_offset  (rest_offset),
    .rest_length  (rest_length)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Id bytes after dropping leading zero bytes, at least one
  function automatic int id_width(input logic [31:0] sid);
    if (sid[31:24] != 8'h0) return 4;
    if (sid[23:16] != 8'h0) return 3;
    if (sid[15:8] != 8'h0)  return 2;
    return 1;
  endfunction

  function automatic off_code_t offset_code(input logic [63:0] offset);
    if (offset == 64'h0)          return OFF_NONE;
    if (offset[63:16] == 48'h0)   return OFF_2B;
    if (offset[63:32] == 32'h0)   return OFF_4B;
    return OFF_8B;
  endfunction

  // Header bytes that do not depend on the data: type, id, offset, length
  function automatic int fixed_bytes(input chunk_t c);
    off_code_t code;
    code = offset_code(c.offset);
    return 3 + id_width(c.sid) + ((code == OFF_NONE) ? 0 : (1 << int'(code)));
  endfunction

  // Frame header words for one chunk; returns the word count
  function automatic int encode_header(input chunk_t c, output hdr_word_t w [MAX_BYTES]);
    int          id_n;
    int          ovh;
    int          avail;
    int          n;
    int          off_n;
    off_code_t   code;
    logic [15:0] taken;
    logic [15:0] rlen;
    logic [63:0] roff;
    logic        split_f;
    logic        fin_f;
    byte_t       hb [MAX_BYTES];
    id_n  = id_width(c.sid);
    code  = offset_code(c.offset);
    ovh   = fixed_bytes(c);
    off_n = ovh - 3 - id_n;
    // no room for the header plus one data byte
    if (int'(c.room) < ovh + 1) begin
      w[0] = '{8'h00, 1'b1, 1'b0, 16'h0, 1'b0, 64'h0, 16'h0};
      return 1;
    end
    avail   = int'(c.room) - ovh;
    fin_f   = c.fin;
    split_f = 1'b0;
    taken   = c.len;
    roff    = 64'h0;
    rlen    = 16'h0;
    if (avail < int'(c.len)) begin
      split_f = 1'b1;
      fin_f   = 1'b0;
      taken   = 16'(avail);
      roff    = c.offset + 64'(avail);
      rlen    = c.len - taken;
    end
    hb[0] = TYPE_BASE | (8'(id_n - 1) << 3) | {5'b0, code, 1'b0}
            | (fin_f ? FIN_BIT : 8'h00);
    n = 1;
    for (int i = id_n - 1; i >= 0; i--) begin
      hb[n] = c.sid[8*i +: 8];
      n++;
    end
    for (int i = off_n - 1; i >= 0; i--) begin
      hb[n] = c.offset[8*i +: 8];
      n++;
    end
    hb[n]     = taken[15:8];
    hb[n + 1] = taken[7:0];
    n += 2;
    for (int k = 0; k < n; k++)
      w[k] = '{hb[k], (k == n - 1), 1'b1, taken, split_f, roff, rlen};
    return n;
  endfunction

  // Random descriptor, biased toward the fit and split thresholds
  function automatic chunk_t random_chunk();
    chunk_t c;
    int     r;
    int     w;
    case ($urandom_range(0, 9))
      0:       c.sid = 32'h0;
      1:       c.sid = 32'hFFFF_FFFF;
      default: begin
        w     = $urandom_range(1, 4);
        c.sid = $urandom & (32'hFFFF_FFFF >> (8 * (4 - w)));
      end
    endcase
    case ($urandom_range(0, 7))
      0: c.offset = 64'h0;
      1: c.offset = {48'h0, 16'($urandom)};
      2: c.offset = {32'h0, 32'($urandom)};
      3, 4: c.offset = {32'($urandom), 32'($urandom)};
      5: c.offset = ONES64 - 64'($urandom_range(0, 300));
      6: begin
        case ($urandom_range(0, 3))
          0: c.offset = 64'hFFFF;
          1: c.offset = 64'h1_0000;
          2: c.offset = 64'hFFFF_FFFF;
          default: c.offset = 64'h1_0000_0000;
        endcase
      end
      default: c.offset = 64'h1;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: c.len = 16'($urandom_range(0, 64));
      4:          c.len = 16'($urandom);
      5:          c.len = 16'hFFFF;
      6:          c.len = 16'h0;
      default:    c.len = 16'($urandom_range(0, 2000));
    endcase
    c.fin = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: r = fixed_bytes(c) + int'(c.len) + $urandom_range(0, 6) - 3;
      5:             r = fixed_bytes(c) + $urandom_range(0, 2);
      6:             r = int'($urandom_range(0, 65535));
      default:       r = 65535;
    endcase
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    c.room = 16'(r);
    return c;
  endfunction

  // Hold start low with junk on the data ports for a random idle gap
  task automatic idle_gap();
    start        = 1'b0;
    stream_id    = $urandom;
    byte_offset  = {32'($urandom), 32'($urandom)};
    chunk_length = 16'($urandom);
    fin_flag     = 1'($urandom_range(0, 1));
    room_left    = 16'($urandom);
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  // Present one descriptor at a falling edge, queue its words on acceptance
  task automatic send_chunk(input chunk_t c, input hdr_word_t w [MAX_BYTES], input int n);
    start        = 1'b1;
    stream_id    = c.sid;
    byte_offset  = c.offset;
    chunk_length = c.len;
    fin_flag     = c.fin;
    room_left    = c.room;
    do @(posedge clk); while (busy);
    for (int k = 0; k < n; k++) pending_words = {pending_words, w[k]};
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Every strobed word is matched against the oldest owed word
  always @(posedge clk) begin : word_check
    hdr_word_t exp_w;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: header_byte %02h last_byte %0b", header_byte, last_byte);
        n_fail++;
      end else begin
        exp_w = pending_words.pop_front();
        check_field("header_byte", 64'(exp_w.hbyte), 64'(header_byte));
        check_field("last_byte", 64'(exp_w.last), 64'(last_byte));
        check_field("fits", 64'(exp_w.fits), 64'(fits));
        check_field("taken_length", 64'(exp_w.taken), 64'(taken_length));
        check_field("was_split", 64'(exp_w.split), 64'(was_split));
        check_field("rest_offset", exp_w.roff, rest_offset);
        check_field("rest_length", 64'(exp_w.rlen), 64'(rest_length));
      end
    end
  end

  initial begin : stimulus
    hdr_word_t words [MAX_BYTES];
    int        n;
    int        wait_cycles;
    chunk_t    c;
    rst          = 1'b1;
    start        = 1'b0;
    stream_id    = 32'h0;
    byte_offset  = 64'h0;
    chunk_length = 16'h0;
    fin_flag     = 1'b0;
    room_left    = 16'h0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; hand-typed words override the predictor where given
    for (int r = 0; r < N_DIR; r++) begin
      if ($urandom_range(0, 99) < 30) idle_gap();
      n = encode_header(dir_rows[r].chunk, words);
      if (dir_rows[r].kind == ROW_NO_FIT) begin
        words[0] = '{8'h00, 1'b1, 1'b0, 16'h0, 1'b0, 64'h0, 16'h0};
        n        = 1;
      end else if (dir_rows[r].kind == ROW_TYPE) begin
        words[0].hbyte = dir_rows[r].type_byte;
      end
      send_chunk(dir_rows[r].chunk, words, n);
    end

    // Random descriptors; items 80..139 go back to back with no gaps
    for (int i = 0; i < N_RANDOM; i++) begin
      if ((i < 80 || i >= 140) && $urandom_range(0, 99) < 30) idle_gap();
      c = random_chunk();
      n = encode_header(c, words);
      send_chunk(c, words, n);
    end
    start = 1'b0;

    // Drain: wait for every owed word, then keep watching for stray extra words
    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d header words never arrived", pending_words.size());
      n_fail++;
    end

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard: the slowest correct run is well under 100 us
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
